>>> sv/otq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int VAL_W       = 20;
	localparam int CMD_W       = 2;
	localparam int IDX_IN_W    = 4;
	localparam int STAT_W      = 2;
	localparam int CNT_OUT_W   = 5;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W       = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [VAL_W-1:0]    vpn;
		logic [VAL_W-1:0]    pfn;
		logic [IDX_IN_W-1:0] index;
	} req_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [VAL_W-1:0]     vpn_out;
		logic [VAL_W-1:0]     pfn_out;
		logic [CNT_OUT_W-1:0] count_out;
	} rsp_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic                go;
		logic                full;
		logic [CNT_W-1:0]    count;
		logic [CMD_W-1:0]    command;
		logic [VAL_W-1:0]    vpn;
		logic [VAL_W-1:0]    pfn;
		logic [IDX_IN_W-1:0] index;
	} cell_ctrl_t;

	// rippled from cell 0 toward the tail
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] page;
		logic [VAL_W-1:0] frame;
	} chain_t;

endpackage
`default_nettype wire

>>> sv/otq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module otq_cell (
	input  wire logic                     clk,
	input  wire logic [otq_pkg::IDX_W-1:0] cell_idx,
	input  wire otq_pkg::cell_ctrl_t      ctrl,
	input  wire otq_pkg::chain_t          chain_in,
	output otq_pkg::chain_t               chain_out,
	input  wire logic [otq_pkg::VAL_W-1:0] nbr_page,
	input  wire logic [otq_pkg::VAL_W-1:0] nbr_frame,
	output logic [otq_pkg::VAL_W-1:0]     page,
	output logic [otq_pkg::VAL_W-1:0]     frame
);
	import otq_pkg::*;

	logic [VAL_W-1:0] page_q;
	logic [VAL_W-1:0] frame_q;
	logic             occ;
	logic             cand;
	logic             first;
	logic             remove;

	assign occ    = CNT_W'(cell_idx) < ctrl.count;
	assign remove = (ctrl.command == CMD_DEQ) || (ctrl.command == CMD_EXT);

	always_comb begin
		case (ctrl.command)
			CMD_DEQ:  cand = occ && (cell_idx == '0);
			CMD_EXT:  cand = occ && (page_q == ctrl.vpn);
			CMD_READ: cand = occ && (CMP_W'(cell_idx) == CMP_W'(ctrl.index));
			default:  cand = 1'b0;
		endcase
	end

	// only the oldest candidate drives the data chain
	assign first           = cand && !chain_in.hit;
	assign chain_out.hit   = chain_in.hit || cand;
	assign chain_out.page  = chain_in.page | (first ? page_q : '0);
	assign chain_out.frame = chain_in.frame | (first ? frame_q : '0);

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			if (remove && chain_out.hit) begin
				// close the gap: take the younger neighbor
				page_q  <= nbr_page;
				frame_q <= nbr_frame;
			end else if (ctrl.command == CMD_ENQ && !ctrl.full
				&& CNT_W'(cell_idx) == ctrl.count) begin
				page_q  <= ctrl.vpn;
				frame_q <= ctrl.pfn;
			end
		end
	end

	assign page  = page_q;
	assign frame = frame_q;

endmodule
`default_nettype wire

>>> sv/ordered_tlb_queue.sv
// Ordered translation queue, oldest entry first, QUEUE_DEPTH cells.
// Request channel (req_valid/req_ready/req) carries one command word:
// enqueue, dequeue head, extract oldest entry with matching vpn, or read
// the vpn at a position. Response channel (rsp_valid/rsp_ready/rsp) returns
// exactly one word per command: status, vpn_out, pfn_out, count_out.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one command per cycle unless a held response stalls. All cells
// compare in parallel; the first-hit and selected data ripple down the row;
// removal shifts every cell behind the hit forward by one in the same edge.
// The response register decouples the sides: while the receiver stalls, a
// held response blocks new requests only until it is taken (req_ready is
// high whenever the response register is empty or being drained).
// Reset empties the queue (count zero) and drops any pending response;
// cell contents are not cleared and are never visible until written.
`timescale 1ns / 1ps
`default_nettype none
module ordered_tlb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire otq_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output otq_pkg::rsp_word_t      rsp
);
	import otq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;
	rsp_word_t        rsp_d;
	logic             accept;
	logic             full;
	logic             found;
	cell_ctrl_t       ctrl;

	chain_t           chain [0:QUEUE_DEPTH];
	logic [VAL_W-1:0] page_w  [0:QUEUE_DEPTH-1];
	logic [VAL_W-1:0] frame_w [0:QUEUE_DEPTH-1];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = count_q == DEPTH_CNT;

	assign ctrl.go      = accept;
	assign ctrl.full    = full;
	assign ctrl.count   = count_q;
	assign ctrl.command = req.command;
	assign ctrl.vpn     = req.vpn;
	assign ctrl.pfn     = req.pfn;
	assign ctrl.index   = req.index;

	assign chain[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] nbr_page;
		logic [VAL_W-1:0] nbr_frame;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr_page  = '0;
			assign nbr_frame = '0;
		end else begin : g_body
			assign nbr_page  = page_w[i+1];
			assign nbr_frame = frame_w[i+1];
		end
		otq_cell u_cell (
			.clk       (clk),
			.cell_idx  (IDX_W'(i)),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.nbr_page  (nbr_page),
			.nbr_frame (nbr_frame),
			.page      (page_w[i]),
			.frame     (frame_w[i])
		);
	end

	assign found = chain[QUEUE_DEPTH].hit;

	always_comb begin
		count_d       = count_q;
		rsp_d.status  = ST_OK;
		rsp_d.vpn_out = '0;
		rsp_d.pfn_out = '0;
		case (req.command)
			CMD_ENQ: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_DEQ, CMD_EXT: begin
				if (found) begin
					rsp_d.vpn_out = chain[QUEUE_DEPTH].page;
					rsp_d.pfn_out = chain[QUEUE_DEPTH].frame;
					count_d       = count_q - 1'b1;
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			CMD_READ: begin
				if (found) begin
					rsp_d.vpn_out = chain[QUEUE_DEPTH].page;
				end else begin
					rsp_d.status = ST_RANGE;
				end
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
		rsp_d.count_out = CNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

>>> sv/otq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module otq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire otq_pkg::rsp_word_t rsp
);
	import otq_pkg::*;

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// requests are blocked only by a stalled response
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request side stalled without cause");

	// an accepted request yields a response word next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("missing response word");

	// a dropped enqueue only happens at full count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL
		|-> rsp.count_out == CNT_OUT_W'(QUEUE_DEPTH))
		else $error("full status with queue not full");

	// failed commands return no entry data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_MISS || rsp.status == ST_RANGE)
		|-> rsp.vpn_out == '0 && rsp.pfn_out == '0)
		else $error("failed command returned entry data");

endmodule

bind ordered_tlb_queue otq_checker u_otq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

>>> test/tb_ordered_tlb_queue.sv
`timescale 1ns / 1ps
module tb_ordered_tlb_queue;
	import otq_pkg::*;

	localparam int RANDOM_WORDS = 1414;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 80;

	typedef struct {
		req_word_t word;
		int        reps;
		bit        typed;
		rsp_word_t want;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	// shadow of the translation queue, oldest first
	logic [VAL_W-1:0] tlb_page [QUEUE_DEPTH];
	logic [VAL_W-1:0] tlb_frame [QUEUE_DEPTH];
	int               tlb_fill = 0;

	rsp_word_t pending_rsp [$];
	int        mismatches = 0;
	int        cycle_count = 0;
	bit        quiet = 1'b0;
	bit        in_random = 1'b0;
	logic      hold_off = 1'b0;
	stim_row_t plan [22];

	ordered_tlb_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < tlb_fill; i++) begin
			tlb_page[i] = tlb_page[i + 1];
			tlb_frame[i] = tlb_frame[i + 1];
		end
		tlb_fill--;
	endfunction

	function automatic rsp_word_t resolve_command(req_word_t w);
		rsp_word_t r;
		int hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		case (w.command)
			CMD_ENQ: begin
				if (tlb_fill >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tlb_page[tlb_fill] = w.vpn;
					tlb_frame[tlb_fill] = w.pfn;
					tlb_fill++;
				end
			end
			CMD_DEQ: begin
				if (tlb_fill == 0) begin
					r.status = ST_MISS;
				end else begin
					r.vpn_out = tlb_page[0];
					r.pfn_out = tlb_frame[0];
					drop_entry(0);
				end
			end
			CMD_EXT: begin
				for (int i = 0; i < tlb_fill; i++)
					if (hit < 0 && tlb_page[i] == w.vpn)
						hit = i;
				if (hit < 0) begin
					r.status = ST_MISS;
				end else begin
					r.vpn_out = tlb_page[hit];
					r.pfn_out = tlb_frame[hit];
					drop_entry(hit);
				end
			end
			default: begin
				if (int'(w.index) >= tlb_fill)
					r.status = ST_RANGE;
				else
					r.vpn_out = tlb_page[w.index];
			end
		endcase
		r.count_out = CNT_OUT_W'(tlb_fill);
		return r;
	endfunction

	// lean: 0 grows the queue, 1 drains it, 2 keeps it balanced
	function automatic req_word_t draw_command(int lean);
		req_word_t w;
		int pick;
		int roll;
		pick = $urandom_range(99);
		w.vpn = VAL_W'($urandom());
		w.pfn = VAL_W'($urandom());
		w.index = IDX_IN_W'($urandom_range(15));
		if (lean == 0)
			w.command = pick < 60 ? CMD_ENQ : pick < 70 ? CMD_DEQ : pick < 85 ? CMD_EXT : CMD_READ;
		else if (lean == 1)
			w.command = pick < 15 ? CMD_ENQ : pick < 50 ? CMD_DEQ : pick < 85 ? CMD_EXT : CMD_READ;
		else
			w.command = pick < 30 ? CMD_ENQ : pick < 50 ? CMD_DEQ : pick < 75 ? CMD_EXT : CMD_READ;
		roll = $urandom_range(99);
		// small key pool so duplicates and repeated hits show up
		if (roll < 35)
			w.vpn = VAL_W'($urandom_range(7));
		else if (roll < 40)
			w.vpn = '1;
		if ($urandom_range(19) == 0)
			w.pfn = $urandom_range(1) ? '1 : '0;
		if (w.command == CMD_EXT && tlb_fill > 0 && $urandom_range(99) < 70)
			w.vpn = tlb_page[$urandom_range(tlb_fill - 1)];
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	task automatic report_mismatch(input string note);
		$display("%0t: %s", $realtime, note);
		mismatches++;
	endtask

	task automatic check_word(input rsp_word_t got);
		rsp_word_t want;
		if (pending_rsp.size() == 0) begin
			report_mismatch($sformatf("response word with nothing outstanding: %h", got));
		end else begin
			want = pending_rsp.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.vpn_out !== want.vpn_out)
				report_mismatch($sformatf("vpn_out got %h want %h", got.vpn_out, want.vpn_out));
			if (got.pfn_out !== want.pfn_out)
				report_mismatch($sformatf("pfn_out got %h want %h", got.pfn_out, want.pfn_out));
			if (got.count_out !== want.count_out)
				report_mismatch($sformatf("count_out got %0d want %0d", got.count_out,
					want.count_out));
		end
	endtask

	// drive one request word and hold it until the block takes it
	task automatic put_word(input req_word_t w, input bit typed, input rsp_word_t want);
		int gap;
		rsp_word_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = resolve_command(w);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_ordered_tlb_queue failed");
		$finish;
	end

	// response side
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				check_word(rsp);
			if (hold_off) begin
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// one long back-pressure window while requests keep coming
	initial begin
		wait (in_random);
		repeat (300) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		req_word_t w;
		int lean;
		plan = '{
			'{'{CMD_DEQ, 20'h0, 20'h0, 4'h0}, 1, 1'b1, '{ST_MISS, 20'h0, 20'h0, 5'd0}},
			'{'{CMD_EXT, 20'h0, 20'h0, 4'h0}, 1, 1'b1, '{ST_MISS, 20'h0, 20'h0, 5'd0}},
			'{'{CMD_READ, 20'h0, 20'h0, 4'h0}, 1, 1'b1, '{ST_RANGE, 20'h0, 20'h0, 5'd0}},
			'{'{CMD_ENQ, 20'hFFFFF, 20'h0, 4'h0}, 1, 1'b1, '{ST_OK, 20'h0, 20'h0, 5'd1}},
			'{'{CMD_ENQ, 20'h0, 20'hFFFFF, 4'hF}, 1, 1'b1, '{ST_OK, 20'h0, 20'h0, 5'd2}},
			'{'{CMD_READ, 20'h0, 20'h0, 4'h1}, 1, 1'b1, '{ST_OK, 20'h0, 20'h0, 5'd2}},
			'{'{CMD_READ, 20'h0, 20'h0, 4'h2}, 1, 1'b1, '{ST_RANGE, 20'h0, 20'h0, 5'd2}},
			'{'{CMD_ENQ, 20'hFFFFF, 20'h12345, 4'h0}, 1, 1'b1, '{ST_OK, 20'h0, 20'h0, 5'd3}},
			// duplicate key: the older entry goes first
			'{'{CMD_EXT, 20'hFFFFF, 20'h0, 4'h0}, 1, 1'b1, '{ST_OK, 20'hFFFFF, 20'h0, 5'd2}},
			'{'{CMD_READ, 20'h0, 20'h0, 4'h1}, 1, 1'b0, '0},
			'{'{CMD_EXT, 20'h55555, 20'h0, 4'h0}, 1, 1'b1, '{ST_MISS, 20'h0, 20'h0, 5'd2}},
			'{'{CMD_DEQ, 20'h0, 20'h0, 4'h0}, 1, 1'b1, '{ST_OK, 20'h0, 20'hFFFFF, 5'd1}},
			'{'{CMD_ENQ, 20'h80000, 20'h7FFFF, 4'h0}, 15, 1'b0, '0},
			'{'{CMD_ENQ, 20'hAAAAA, 20'h55555, 4'h0}, 1, 1'b1, '{ST_FULL, 20'h0, 20'h0, 5'd16}},
			'{'{CMD_READ, 20'h0, 20'h0, 4'hF}, 1, 1'b0, '0},
			'{'{CMD_READ, 20'h0, 20'h0, 4'h0}, 1, 1'b1, '{ST_OK, 20'hFFFFF, 20'h0, 5'd16}},
			'{'{CMD_EXT, 20'h8000E, 20'h0, 4'h0}, 1, 1'b0, '0},
			'{'{CMD_EXT, 20'h80005, 20'h0, 4'h0}, 1, 1'b0, '0},
			'{'{CMD_ENQ, 20'hAAAAA, 20'h55555, 4'h0}, 1, 1'b0, '0},
			'{'{CMD_DEQ, 20'h0, 20'h0, 4'h0}, 1, 1'b0, '0},
			'{'{CMD_READ, 20'h0, 20'h0, 4'hF}, 1, 1'b1, '{ST_RANGE, 20'h0, 20'h0, 5'd14}},
			'{'{CMD_EXT, 20'hAAAAA, 20'h0, 4'h0}, 1, 1'b0, '0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			for (int i = 0; i < plan[r].reps; i++) begin
				w = plan[r].word;
				w.vpn = w.vpn + VAL_W'(i);
				w.pfn = w.pfn - VAL_W'(i);
				put_word(w, plan[r].typed, plan[r].want);
			end
		end

		in_random = 1'b1;
		lean = 2;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) begin
				lean = $urandom_range(2);
				quiet = ($urandom_range(3) == 0);
			end
			put_word(draw_command(lean), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_ordered_tlb_queue passed");
		else
			$display("tb_ordered_tlb_queue failed");
		$finish;
	end

endmodule
